>>> rtl/core/glmu_pkg.sv
`default_nettype none
package glmu_pkg;

  // command codes
  localparam logic [1:0] CMD_TRIAL     = 2'd0;
  localparam logic [1:0] CMD_LOAD_SPIN = 2'd1;
  localparam logic [1:0] CMD_LOAD_DIS  = 2'd2;
  localparam logic [1:0] CMD_LOAD_THR  = 2'd3;

  // direction code that names no link
  localparam logic [1:0] DIR_NONE = 2'd3;

  localparam int COORD_W     = 4;
  localparam int TIDX_W      = 5;
  localparam int TABLE_DEPTH = 25;
  localparam logic [32:0] THR_MAX = 33'h1_0000_0000;

  // last step of a trial's read sweep: target, then 4 plaquettes x 3 links
  localparam logic [3:0] LAST_STEP = 4'd12;

  typedef struct packed {
    logic [1:0]         command;
    logic [1:0]         direction;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic               bit_value;
    logic [TIDX_W-1:0]  table_index;
    logic [31:0]        random_draw;
    logic [32:0]        threshold;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       spin_after;
    logic [2:0] neg_plaquettes;
    logic [2:0] neg_weighted;
  } out_item_t;

  // position of a read step within the sweep
  typedef struct packed {
    logic       target;  // the trial link itself
    logic [1:0] plaq;    // bit 1: second side axis, bit 0: lower plaquette
    logic [1:0] link;    // 0 side link, 1 shifted side link, 2 shifted parallel link
  } step_pos_t;

  function automatic step_pos_t step_decode(input logic [3:0] st);
    step_pos_t p;
    p = '0;
    case (st)
      4'd0:  p = '{target: 1'b1, plaq: 2'd0, link: 2'd0};
      4'd1:  p = '{target: 1'b0, plaq: 2'd0, link: 2'd0};
      4'd2:  p = '{target: 1'b0, plaq: 2'd0, link: 2'd1};
      4'd3:  p = '{target: 1'b0, plaq: 2'd0, link: 2'd2};
      4'd4:  p = '{target: 1'b0, plaq: 2'd1, link: 2'd0};
      4'd5:  p = '{target: 1'b0, plaq: 2'd1, link: 2'd1};
      4'd6:  p = '{target: 1'b0, plaq: 2'd1, link: 2'd2};
      4'd7:  p = '{target: 1'b0, plaq: 2'd2, link: 2'd0};
      4'd8:  p = '{target: 1'b0, plaq: 2'd2, link: 2'd1};
      4'd9:  p = '{target: 1'b0, plaq: 2'd2, link: 2'd2};
      4'd10: p = '{target: 1'b0, plaq: 2'd3, link: 2'd0};
      4'd11: p = '{target: 1'b0, plaq: 2'd3, link: 2'd1};
      4'd12: p = '{target: 1'b0, plaq: 2'd3, link: 2'd2};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/glmu_addr_gen.sv
`default_nettype none
// Link and disorder addresses for one step of the plaquette sweep.
module glmu_addr_gen import glmu_pkg::*; #(
  parameter int LATTICE_SIZE = 16,
  localparam int CW = $clog2(LATTICE_SIZE),
  localparam int AW = 2 + 3 * CW
) (
  input  wire logic [1:0]    dir,
  input  wire logic [CW-1:0] coord [3],
  input  wire step_pos_t     pos,
  output logic [AW-1:0]      link_addr,
  output logic [AW-1:0]      dis_addr
);

  logic [1:0]    side;
  logic [1:0]    normal;
  logic [1:0]    link_dir;
  logic [CW-1:0] base [3];
  logic [CW-1:0] q [3];

  function automatic logic [CW-1:0] wrap_up(input logic [CW-1:0] v);
    return (v == CW'(LATTICE_SIZE - 1)) ? '0 : CW'(v + 1'b1);
  endfunction

  function automatic logic [CW-1:0] wrap_dn(input logic [CW-1:0] v);
    return (v == '0) ? CW'(LATTICE_SIZE - 1) : CW'(v - 1'b1);
  endfunction

  always_comb begin
    // side axis: dir+1 or dir+2, modulo three
    case (dir)
      2'd0:    side = pos.plaq[1] ? 2'd2 : 2'd1;
      2'd1:    side = pos.plaq[1] ? 2'd0 : 2'd2;
      2'd2:    side = pos.plaq[1] ? 2'd1 : 2'd0;
      default: side = 2'd0;
    endcase
    normal = 2'(2'd3 - dir - side);

    for (int i = 0; i < 3; i++) begin
      base[i] = (pos.plaq[0] && side == 2'(i)) ? wrap_dn(coord[i]) : coord[i];
    end

    q        = base;
    link_dir = side;
    if (pos.target) begin
      link_dir = dir;
      q        = coord;
    end else begin
      case (pos.link)
        2'd1: begin
          for (int i = 0; i < 3; i++) begin
            if (dir == 2'(i)) q[i] = wrap_up(base[i]);
          end
        end
        2'd2: begin
          // upper plaquette: parallel link one up the side axis;
          // lower plaquette: parallel link at the lower corner itself
          link_dir = dir;
          for (int i = 0; i < 3; i++) begin
            if (side == 2'(i) && !pos.plaq[0]) q[i] = wrap_up(base[i]);
          end
        end
        default: ;
      endcase
    end

    link_addr = {link_dir, q[0], q[1], q[2]};
    dis_addr  = {normal, base[0], base[1], base[2]};
  end

endmodule
`default_nettype wire

>>> rtl/core/gauge_lattice_metropolis_update_top.sv
`default_nettype none
// Trial: 13 reads of the single-port spin store, one link per cycle, then a table
//   read; busy stays high until the result is set.
// Load spin and direction-three items report at dispatch, others via a spin read.
// Reset (rst_n low, synchronous) clears all 3 * 2^(3*clog2(LATTICE_SIZE)) spin
//   store entries (12288 at 16) in one pass; busy stays high meanwhile.
// Results are a one-cycle strobe; the receiver cannot stall.
module gauge_lattice_metropolis_update_top import glmu_pkg::*; #(
  parameter int LATTICE_SIZE = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item
);

  localparam int CW    = $clog2(LATTICE_SIZE);
  localparam int AW    = 2 + 3 * CW;
  localparam int DEPTH = 3 << (3 * CW);

  // sequencer codes
  localparam logic [2:0] S_CLEAR = 3'd0;  // zeroing the spin store
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;  // dispatch on command
  localparam logic [2:0] S_ISSUE = 3'd3;  // read sweep, one link per cycle
  localparam logic [2:0] S_DRAIN = 3'd4;  // last read lands
  localparam logic [2:0] S_TBL   = 3'd5;  // threshold lookup
  localparam logic [2:0] S_DEC   = 3'd6;  // compare, flip, report
  localparam logic [2:0] S_RDOUT = 3'd7;  // report a plain spin read

  // control
  logic [2:0]    state_r, state_nxt;
  logic [3:0]    step_r, step_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          out_valid_r;
  logic          rd_vld_r;
  logic          out_set;
  out_item_t     out_nxt;
  logic          in_acc;

  // latched item
  logic [1:0]        cmd_r;
  logic [1:0]        dir_r;
  logic              bit_r;
  logic [TIDX_W-1:0] tidx_r;
  logic [31:0]       draw_r;
  logic [32:0]       thr_r;
  logic [CW-1:0]     c_r [3];
  logic [CW-1:0]     red_tab [16];

  // sweep datapath
  logic [3:0]    rd_tag_r;
  logic          t_r;
  logic          par_r;
  logic          prod;
  logic [2:0]    negp_r;
  logic [2:0]    negw_r;
  logic          acc;
  out_item_t     out_item_r;
  step_pos_t     pos_issue;
  step_pos_t     pos_tag;
  logic [AW-1:0] gen_link_addr;
  logic [AW-1:0] gen_dis_addr;
  logic [AW-1:0] tgt_addr;

  // stores
  logic          spin_mem_r [DEPTH];
  logic          dis_mem_r [DEPTH];
  logic [32:0]   thr_mem_r [TABLE_DEPTH];
  logic          spin_q_r;
  logic          dis_q_r;
  logic [32:0]   thr_q_r;
  logic          spin_we, spin_re, spin_wd;
  logic [AW-1:0] spin_addr;
  logic          dis_we, dis_re;
  logic [AW-1:0] dis_addr;
  logic          thr_we, thr_re;
  logic [TIDX_W-1:0] thr_raddr;

  assign busy      = (state_r != S_IDLE);
  assign in_acc    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // coordinate reduction modulo lattice size, built at elaboration
  for (genvar i = 0; i < 16; i++) begin : g_red
    localparam int RedVal = i % LATTICE_SIZE;
    assign red_tab[i] = CW'(RedVal);
  end

  assign pos_issue = step_decode(step_r);
  assign pos_tag   = step_decode(rd_tag_r);
  assign tgt_addr  = {dir_r, c_r[0], c_r[1], c_r[2]};
  assign thr_raddr = TIDX_W'({negp_r, 2'b00}) + TIDX_W'(negp_r) + TIDX_W'(negw_r);
  assign acc       = ({1'b0, draw_r} < thr_q_r);

  glmu_addr_gen #(
    .LATTICE_SIZE (LATTICE_SIZE)
  ) u_addr_gen (
    .dir       (dir_r),
    .coord     (c_r),
    .pos       (pos_issue),
    .link_addr (gen_link_addr),
    .dis_addr  (gen_dis_addr)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    clr_nxt   = clr_r;
    spin_we   = 1'b0;
    spin_re   = 1'b0;
    spin_wd   = 1'b0;
    spin_addr = gen_link_addr;
    dis_we    = 1'b0;
    dis_re    = 1'b0;
    dis_addr  = gen_dis_addr;
    thr_we    = 1'b0;
    thr_re    = 1'b0;
    out_set   = 1'b0;
    out_nxt   = '0;
    case (state_r)
      S_CLEAR: begin
        spin_we   = 1'b1;
        spin_addr = clr_r;
        clr_nxt   = AW'(clr_r + 1'b1);
        if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // table loads happen whatever the direction
        thr_we = (cmd_r == CMD_LOAD_THR) && (tidx_r < TIDX_W'(TABLE_DEPTH));
        if (dir_r == DIR_NONE) begin
          out_set   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          case (cmd_r)
            CMD_TRIAL: begin
              step_nxt  = '0;
              state_nxt = S_ISSUE;
            end
            CMD_LOAD_SPIN: begin
              spin_we            = 1'b1;
              spin_addr          = tgt_addr;
              spin_wd            = bit_r;
              out_set            = 1'b1;
              out_nxt.spin_after = bit_r;
              state_nxt          = S_IDLE;
            end
            CMD_LOAD_DIS: begin
              dis_we    = 1'b1;
              dis_addr  = tgt_addr;
              spin_re   = 1'b1;
              spin_addr = tgt_addr;
              state_nxt = S_RDOUT;
            end
            default: begin
              spin_re   = 1'b1;
              spin_addr = tgt_addr;
              state_nxt = S_RDOUT;
            end
          endcase
        end
      end
      S_ISSUE: begin
        spin_re = 1'b1;
        // disorder of a plaquette comes with its first link
        dis_re  = !pos_issue.target && (pos_issue.link == 2'd0);
        if (step_r == LAST_STEP) state_nxt = S_DRAIN;
        else step_nxt = step_r + 4'd1;
      end
      S_DRAIN: begin
        state_nxt = S_TBL;
      end
      S_TBL: begin
        thr_re    = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (acc) begin
          spin_we   = 1'b1;
          spin_addr = tgt_addr;
          spin_wd   = ~t_r;
        end
        out_set                = 1'b1;
        out_nxt.accepted       = acc;
        out_nxt.spin_after     = t_r ^ acc;
        out_nxt.neg_plaquettes = negp_r;
        out_nxt.neg_weighted   = negw_r;
        state_nxt              = S_IDLE;
      end
      S_RDOUT: begin
        out_set            = 1'b1;
        out_nxt.spin_after = spin_q_r;
        state_nxt          = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      step_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_set;
      rd_vld_r    <= (state_r == S_ISSUE);
    end
  end

  // item capture, result register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_item.command;
      dir_r  <= in_item.direction;
      bit_r  <= in_item.bit_value;
      tidx_r <= in_item.table_index;
      draw_r <= in_item.random_draw;
      thr_r  <= in_item.threshold;
      c_r[0] <= red_tab[in_item.coord_x];
      c_r[1] <= red_tab[in_item.coord_y];
      c_r[2] <= red_tab[in_item.coord_z];
    end
    if (out_set) out_item_r <= out_nxt;
  end

  // sweep accumulation: reads land in the cycle after issue, tagged by step
  assign prod = par_r ^ spin_q_r;

  always_ff @(posedge clk) begin
    rd_tag_r <= step_r;
    if (state_r == S_EXEC) begin
      negp_r <= '0;
      negw_r <= '0;
    end else if (rd_vld_r) begin
      if (pos_tag.target) begin
        t_r <= spin_q_r;
      end else begin
        case (pos_tag.link)
          2'd0: par_r <= t_r ^ spin_q_r;
          2'd1: par_r <= par_r ^ spin_q_r;
          default: begin
            negp_r <= negp_r + 3'(prod);
            negw_r <= negw_r + 3'(prod ^ dis_q_r);
          end
        endcase
      end
    end
  end

  // spin store: one port
  always_ff @(posedge clk) begin
    if (spin_we) spin_mem_r[spin_addr] <= spin_wd;
    else if (spin_re) spin_q_r <= spin_mem_r[spin_addr];
  end

  // disorder store: one port, no reset
  always_ff @(posedge clk) begin
    if (dis_we) dis_mem_r[dis_addr] <= bit_r;
    else if (dis_re) dis_q_r <= dis_mem_r[dis_addr];
  end

  // threshold table, saturated at 2^32 on load
  always_ff @(posedge clk) begin
    if (thr_we) thr_mem_r[tidx_r] <= (thr_r > THR_MAX) ? THR_MAX : thr_r;
    if (thr_re) thr_q_r <= thr_mem_r[thr_raddr];
  end

  // checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy)
    else $error("block not busy after taking an item");

  a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result during clearing pass");

  a_read_window: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_ISSUE || state_r == S_DRAIN))
    else $error("sweep read landed outside the sweep");

endmodule
`default_nettype wire

>>> dv/tb_gauge_lattice_metropolis_update_top.sv
`timescale 1ns / 1ps

module tb_gauge_lattice_metropolis_update_top;
  import glmu_pkg::*;

  localparam int LSIZE = 16;
  localparam int SITES = LSIZE * LSIZE * LSIZE;
  localparam int LINKS = 3 * SITES;

  // x, y, z as one packed vector so an axis can be picked by number
  typedef logic [2:0][COORD_W-1:0] site_t;

  // an item waiting in the driver queue, with the idling it is sent under
  typedef struct packed {
    in_item_t   item;
    logic [6:0] idle_pct;
    logic       drain_first;  // hold until every outstanding result is back
  } queued_cmd_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  logic took = 1'b0;  // item taken at the last rising edge

  queued_cmd_t cmd_queue[$];
  out_item_t   expected_outcomes[$];
  int          mismatch_count = 0;

  // lattice as the testbench sees it
  bit          spin_mem[0:LINKS-1];
  bit          dis_mem[0:LINKS-1];
  logic [32:0] thr_table[0:TABLE_DEPTH-1];

  // stimulus-side bookkeeping: disorders already loaded, current idling
  bit dis_loaded[0:LINKS-1];
  int gen_idle = 0;
  bit gen_drain = 1'b0;

  gauge_lattice_metropolis_update_top #(
    .LATTICE_SIZE(LSIZE)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Reset is held low from the start and released on a falling edge. The block then
  // clears its spin store on its own, with busy high the whole time.
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------
  // Lattice arithmetic
  // ---------------------------------------------------------------------

  function automatic int cell_idx(int d, site_t c);
    return ((d * LSIZE + int'(c[0])) * LSIZE + int'(c[1])) * LSIZE + int'(c[2]);
  endfunction

  function automatic int wrap_up(int v);
    return (v + 1) % LSIZE;
  endfunction

  function automatic int wrap_down(int v);
    return (v + LSIZE - 1) % LSIZE;
  endfunction

  // spin product bit of the plaquette spanned by axes o and s, lower corner b
  function automatic int plaq_product(int o, int s, site_t b);
    site_t p;
    int    v;
    v = spin_mem[cell_idx(o, b)] ^ spin_mem[cell_idx(s, b)];
    p = b;
    p[o] = COORD_W'(wrap_up(b[o]));
    v ^= spin_mem[cell_idx(s, p)];
    p = b;
    p[s] = COORD_W'(wrap_up(b[s]));
    v ^= spin_mem[cell_idx(o, p)];
    return v & 1;
  endfunction

  // Applies one accepted item to the lattice copy and returns its result.
  // A trial looks at the four plaquettes on the link: for each of the two
  // other axes, the one above and the one below.
  function automatic out_item_t lattice_step(in_item_t it);
    out_item_t r;
    site_t     c;
    site_t     m;
    int        d;
    int        s;
    int        n;
    int        k;
    int        pv;
    int        negp;
    int        negw;
    r = '0;
    negp = 0;
    negw = 0;
    d = it.direction;
    c[0] = COORD_W'(int'(it.coord_x) % LSIZE);
    c[1] = COORD_W'(int'(it.coord_y) % LSIZE);
    c[2] = COORD_W'(int'(it.coord_z) % LSIZE);
    if (it.command == CMD_LOAD_THR) begin
      // threshold loads ignore the direction; out-of-range index is dropped
      if (it.table_index < TABLE_DEPTH)
        thr_table[it.table_index] = (it.threshold > THR_MAX) ? THR_MAX : it.threshold;
    end else if (it.direction != DIR_NONE) begin
      case (it.command)
        CMD_LOAD_SPIN: spin_mem[cell_idx(d, c)] = it.bit_value;
        CMD_LOAD_DIS:  dis_mem[cell_idx(d, c)] = it.bit_value;
        CMD_TRIAL: begin
          for (k = 1; k <= 2; k++) begin
            s = (d + k) % 3;
            n = 3 - d - s;  // normal of the plaquettes in the d-s plane
            pv = plaq_product(d, s, c);
            negp += pv;
            negw += pv ^ dis_mem[cell_idx(n, c)];
            m = c;
            m[s] = COORD_W'(wrap_down(c[s]));
            pv = plaq_product(d, s, m);
            negp += pv;
            negw += pv ^ dis_mem[cell_idx(n, m)];
          end
          if ({1'b0, it.random_draw} < thr_table[negp * 5 + negw]) begin
            spin_mem[cell_idx(d, c)] ^= 1'b1;
            r.accepted = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (it.direction != DIR_NONE)
      r.spin_after = spin_mem[cell_idx(d, c)];
    r.neg_plaquettes = negp[2:0];
    r.neg_weighted   = negw[2:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------

  function automatic in_item_t random_item();
    in_item_t it;
    it.command     = 2'($urandom_range(0, 3));
    it.direction   = 2'($urandom_range(0, 3));
    it.coord_x     = COORD_W'($urandom);
    it.coord_y     = COORD_W'($urandom);
    it.coord_z     = COORD_W'($urandom);
    it.bit_value   = 1'($urandom);
    it.table_index = TIDX_W'($urandom);
    it.random_draw = $urandom;
    it.threshold   = {1'($urandom), $urandom};
    return it;
  endfunction

  // mostly a 4x4x4 patch straddling the wrap at 15/0, so loaded spins
  // and flips meet each other and push the counts up to four
  function automatic site_t pick_site();
    site_t c;
    int    a;
    for (a = 0; a < 3; a++) begin
      if ($urandom_range(0, 4) == 0)
        c[a] = COORD_W'($urandom);
      else
        c[a] = COORD_W'((LSIZE - 1 + $urandom_range(0, 3)) % LSIZE);
    end
    return c;
  endfunction

  function automatic logic [32:0] pick_threshold();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return THR_MAX;
      2:       return {1'b1, $urandom};  // above the clamp
      3:       return {1'b0, $urandom >> $urandom_range(0, 31)};
      default: return {1'b0, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] pick_draw();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_cmd(in_item_t it);
    queued_cmd_t q;
    site_t       c;
    q.item        = it;
    q.idle_pct    = 7'(gen_idle);
    q.drain_first = gen_drain;
    gen_drain = 1'b0;
    cmd_queue.push_back(q);
    c = {it.coord_z, it.coord_y, it.coord_x};
    if (it.command == CMD_LOAD_DIS && it.direction != DIR_NONE)
      dis_loaded[cell_idx(it.direction, c)] = 1'b1;
  endtask

  // disorders are undefined until written: load one before it is read
  task automatic cover_disorder(int n, site_t c);
    in_item_t ld;
    if (!dis_loaded[cell_idx(n, c)]) begin
      ld = random_item();
      ld.command   = CMD_LOAD_DIS;
      ld.direction = 2'(n);
      {ld.coord_z, ld.coord_y, ld.coord_x} = c;
      push_cmd(ld);
    end
  endtask

  task automatic queue_cmd(in_item_t it);
    site_t c;
    site_t m;
    int    d;
    int    s;
    int    k;
    c = {it.coord_z, it.coord_y, it.coord_x};
    d = it.direction;
    if (it.command == CMD_TRIAL && it.direction != DIR_NONE) begin
      for (k = 1; k <= 2; k++) begin
        s = (d + k) % 3;
        cover_disorder(3 - d - s, c);
        m = c;
        m[s] = COORD_W'(wrap_down(c[s]));
        cover_disorder(3 - d - s, m);
      end
    end
    push_cmd(it);
  endtask

  task automatic queue_at(logic [1:0] cmd, logic [1:0] dir, site_t c,
                          logic bitv, logic [31:0] draw);
    in_item_t it;
    it = random_item();
    it.command     = cmd;
    it.direction   = dir;
    {it.coord_z, it.coord_y, it.coord_x} = c;
    it.bit_value   = bitv;
    it.random_draw = draw;
    queue_cmd(it);
  endtask

  task automatic queue_thr(int idx, logic [32:0] thr, logic [1:0] dir);
    in_item_t it;
    it = random_item();
    it.command     = CMD_LOAD_THR;
    it.direction   = dir;
    it.table_index = TIDX_W'(idx);
    it.threshold   = thr;
    queue_cmd(it);
  endtask

  task automatic build_directed();
    int i;
    // a trial for direction three changes nothing and reports an all-zero result
    queue_at(CMD_TRIAL, DIR_NONE, '1, 1'b1, '1);
    // whole threshold table first; entry 0 always flips, entry 24 never
    queue_thr(0, 33'h1_FFFF_FFFF, 2'd0);
    for (i = 1; i < TABLE_DEPTH - 1; i++)
      queue_thr(i, pick_threshold(), 2'($urandom_range(0, 2)));
    queue_thr(TABLE_DEPTH - 1, '0, 2'd2);
    queue_thr(31, THR_MAX, 2'd1);  // index out of range: dropped
    gen_drain = 1'b1;
    queue_at(CMD_TRIAL, 2'd0, '0, 1'b0, '1);
    queue_at(CMD_TRIAL, 2'd1, '0, 1'b1, '0);
    queue_at(CMD_LOAD_SPIN, 2'd1, '0, 1'b1, '0);
    queue_at(CMD_TRIAL, 2'd0, '0, 1'b0, '0);
    queue_at(CMD_TRIAL, 2'd2, '1, 1'b0, $urandom);
    queue_at(CMD_LOAD_SPIN, 2'd2, '1, 1'b1, '0);
    queue_at(CMD_LOAD_SPIN, 2'd0, '1, 1'b0, '1);
    queue_at(CMD_TRIAL, 2'd1, '1, 1'b1, '1);
    queue_at(CMD_LOAD_DIS, 2'd2, '0, 1'b1, '0);
    queue_at(CMD_TRIAL, 2'd0, '0, 1'b0, 32'h8000_0000);
    // loads aimed at direction three are dropped, threshold loads are not
    queue_at(CMD_LOAD_SPIN, DIR_NONE, '0, 1'b1, '0);
    queue_at(CMD_LOAD_DIS, DIR_NONE, '1, 1'b1, '0);
    queue_thr(5, 33'h1_0000_0001, DIR_NONE);
    queue_thr(TABLE_DEPTH - 1, 33'h1_FFFF_FFFF, 2'd0);
    queue_at(CMD_TRIAL, 2'd2, '0, 1'b0, 32'hFFFF_FFFE);
  endtask

  // one random item, with any disorder loads its trial needs
  task automatic queue_random();
    in_item_t it;
    int       r;
    it = random_item();
    {it.coord_z, it.coord_y, it.coord_x} = pick_site();
    it.direction   = 2'($urandom_range(0, 2));
    it.random_draw = pick_draw();
    it.threshold   = pick_threshold();
    r = $urandom_range(0, 99);
    if (r < 55) begin
      it.command = CMD_TRIAL;
    end else if (r < 72) begin
      it.command = CMD_LOAD_SPIN;
    end else if (r < 82) begin
      it.command = CMD_LOAD_DIS;
    end else if (r < 93) begin
      it.command = CMD_LOAD_THR;
      it.table_index = TIDX_W'($urandom_range(0, 31));
    end else begin
      it.direction = DIR_NONE;
    end
    queue_cmd(it);
  endtask

  // ---------------------------------------------------------------------
  // Driver: inputs move on the falling edge only. A new item goes out
  // once the previous one was taken, or when start is low.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : driver
    queued_cmd_t head;
    if (rst_n && (!start || took)) begin
      if (cmd_queue.size() != 0
          && !(cmd_queue[0].drain_first && expected_outcomes.size() != 0)
          && $urandom_range(0, 99) >= cmd_queue[0].idle_pct) begin
        head = cmd_queue.pop_front();
        in_item <= head.item;
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------
  // Monitor: results are checked against the oldest expectation before
  // the item taken at the same edge is predicted.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      took <= 1'b0;
    end else begin
      if (out_valid) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_item, 0);
        end else begin
          want = expected_outcomes.pop_front();
          if (out_item.accepted !== want.accepted)
            report_mismatch("accepted", out_item.accepted, want.accepted);
          if (out_item.spin_after !== want.spin_after)
            report_mismatch("spin_after", out_item.spin_after, want.spin_after);
          if (out_item.neg_plaquettes !== want.neg_plaquettes)
            report_mismatch("neg_plaquettes", out_item.neg_plaquettes,
                            want.neg_plaquettes);
          if (out_item.neg_weighted !== want.neg_weighted)
            report_mismatch("neg_weighted", out_item.neg_weighted, want.neg_weighted);
        end
      end
      took <= start && !busy;
      if (start && !busy)
        expected_outcomes.push_back(lattice_step(in_item));
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: directed items, then four random phases of about 200 items
  // each, disorder loads included. Sender idling per phase: none, 70 %,
  // none (the receiver cannot stall), 21 %.
  // ---------------------------------------------------------------------
  initial begin : sequence_ctl
    int phase_idle[4];
    int ph;
    int phase_start;
    bit mid_drained;
    phase_idle = '{0, 70, 0, 21};
    build_directed();
    for (ph = 0; ph < 4; ph++) begin
      gen_idle = phase_idle[ph];
      gen_drain = 1'b1;
      phase_start = cmd_queue.size();
      mid_drained = 1'b0;
      while (cmd_queue.size() - phase_start < 200) begin
        queue_random();
        if (!mid_drained && cmd_queue.size() - phase_start >= 100) begin
          gen_drain = 1'b1;  // drain once mid-phase as well
          mid_drained = 1'b1;
        end
      end
    end

    @(posedge rst_n);
    while (cmd_queue.size() != 0 || start)
      @(posedge clk);
    while (expected_outcomes.size() != 0)
      @(posedge clk);
    // leave room for a stray strobe
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_gauge_lattice_metropolis_update_top: clean");
    else
      $display("tb_gauge_lattice_metropolis_update_top: errors");
    $finish;
  end

  // watchdog for about 850 items plus the clearing pass, with a wide margin
  initial begin : watchdog
    #5_000_000;
    $display("tb_gauge_lattice_metropolis_update_top: errors");
    $finish;
  end

endmodule

>>> gauge_lattice_metropolis_update_top.f
rtl/core/glmu_pkg.sv
rtl/core/glmu_addr_gen.sv
rtl/core/gauge_lattice_metropolis_update_top.sv
dv/tb_gauge_lattice_metropolis_update_top.sv
